/* design/stx_pkg.sv */
// ----------------------------------------------------------------------------
// stx_pkg: shared types and constants for the scrolling text marquee
// Payload structs, register indexes, geometry constants and the 5x7 font.
// ----------------------------------------------------------------------------
package stx_pkg;

  // Screen and strip geometry
  localparam int SCREEN_WIDTH = 30;
  localparam int SCREEN_ROWS  = 7;
  localparam int MAX_CHARS    = 8;
  localparam int GLYPH_WIDTH  = 5;
  localparam int GAP_WIDTH    = 1;
  localparam int GLYPH_ROWS   = 7;
  localparam int CELL_WIDTH   = GLYPH_WIDTH + GAP_WIDTH;

  // Field widths
  localparam int RowW   = 3;
  localparam int FirstW = 8;
  localparam int CodeW  = 4;
  localparam int CodesW = 32;
  localparam int LenW   = 4;
  localparam int ChW    = $clog2(MAX_CHARS);
  localparam int ColW   = $clog2(CELL_WIDTH);

  // Register reset values
  localparam logic [CodesW-1:0] TEXT_CODES_RST  = 32'h3012_3810;
  localparam logic [LenW-1:0]   TEXT_LENGTH_RST = 4'd8;

  // Configuration register indexes
  typedef enum logic {
    REG_TEXT_CODES  = 1'b0,
    REG_TEXT_LENGTH = 1'b1
  } reg_idx_e;

  // Letter codes that own a glyph
  localparam logic [CodeW-1:0] CODE_A = 4'd0;
  localparam logic [CodeW-1:0] CODE_B = 4'd1;
  localparam logic [CodeW-1:0] CODE_C = 4'd2;
  localparam logic [CodeW-1:0] CODE_D = 4'd3;
  localparam logic [CodeW-1:0] CODE_I = 4'd8;

  // Request and result payloads
  typedef struct packed {
    logic [RowW-1:0] row;
    logic            advance;
  } in_t;

  typedef struct packed {
    logic [SCREEN_WIDTH-1:0] led_bits;
    logic [FirstW-1:0]       first_led;
  } out_t;

  // Control from the sequencer to the strip walker
  typedef struct packed {
    logic clear;    // configuration write: drop scroll offset
    logic load;     // new request: start walk at offset, step offset if advance
    logic step;     // move walk one strip column to the right
    logic advance;  // request asks for an offset step
  } stx_ctl_t;

  // Font rows, MSB is the leftmost glyph column
  localparam logic [0:4][0:GLYPH_ROWS-1][GLYPH_WIDTH-1:0] FONT_ROM = '{
    '{5'h04, 5'h0A, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11},
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
    '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
    '{5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C},
    '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}
  };

  // Glyph row for a letter code; letters without a glyph are blank
  function automatic logic [GLYPH_WIDTH-1:0] glyph_row(input logic [CodeW-1:0] code,
                                                       input logic [RowW-1:0]  r);
    logic [GLYPH_WIDTH-1:0] g;
    g = '0;
    if (int'(r) < GLYPH_ROWS) begin
      case (code)
        CODE_A:  g = FONT_ROM[0][r];
        CODE_B:  g = FONT_ROM[1][r];
        CODE_C:  g = FONT_ROM[2][r];
        CODE_D:  g = FONT_ROM[3][r];
        CODE_I:  g = FONT_ROM[4][r];
        default: g = '0;
      endcase
    end
    return g;
  endfunction

endpackage

/* design/scrolling_text_serpentine_matrix.sv */
// ----------------------------------------------------------------------------
// scrolling_text_serpentine_matrix: scrolling text marquee, serpentine chain
// Renders one matrix row per request, one screen column per cycle, and
// gives the row's LED bits in chain order.
// ----------------------------------------------------------------------------
// The strip walker gives one pixel per clock into the row shift register.
// A new request is taken only in idle, once the previous row has been handed
//   to the output register.
// A finished result waits in the output register while the next request runs.
// Reset: async active low; scroll offset zero, text registers to their
//   defaults, no result pending.
module scrolling_text_serpentine_matrix (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  stx_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output stx_pkg::out_t              out_data_o,
  input  logic                       cfg_we_i,
  input  stx_pkg::reg_idx_e          cfg_idx_i,
  input  logic [stx_pkg::CodesW-1:0] cfg_data_i
);
  import stx_pkg::*;

  localparam int CntW = $clog2(SCREEN_WIDTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_HOLD
  } state_e;

  state_e                  state_q;
  logic [CntW-1:0]         cnt_q;
  logic                    odd_q;
  logic [FirstW-1:0]       first_q;
  logic [SCREEN_WIDTH-1:0] sh_q;
  logic                    out_valid_q;
  out_t                    out_q;

  logic [CodesW-1:0] codes_q;
  logic [LenW-1:0]   len_q;
  logic [LenW-1:0]   eff_len;
  logic [ChW-1:0]    last_ch;

  logic              in_acc;
  logic              out_free;
  logic              pix;
  stx_ctl_t          ctl;
  logic [RowW+FirstW-1:0] first_full;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Clamp the text length into 1..MAX_CHARS
  always_comb begin
    if (len_q == '0) begin
      eff_len = LenW'(1);
    end else if (len_q > LenW'(MAX_CHARS)) begin
      eff_len = LenW'(MAX_CHARS);
    end else begin
      eff_len = len_q;
    end
    last_ch = ChW'(eff_len - 1'b1);
  end

  // Drive the walker
  always_comb begin
    ctl.clear   = cfg_we_i;
    ctl.load    = in_acc;
    ctl.step    = (state_q == ST_SHIFT);
    ctl.advance = in_data_i.advance;
  end

  stx_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .row_i     (in_data_i.row),
    .codes_i   (codes_q),
    .last_ch_i (last_ch),
    .pix_o     (pix)
  );

  // Chain index of the row's first LED
  assign first_full = (RowW+FirstW)'(in_data_i.row) * (RowW+FirstW)'(SCREEN_WIDTH);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q <= TEXT_CODES_RST;
      len_q   <= TEXT_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TEXT_CODES:  codes_q <= cfg_data_i;
        REG_TEXT_LENGTH: len_q   <= cfg_data_i[LenW-1:0];
        default:         ;
      endcase
    end
  end

  // Sequencer: load, shift one column per cycle, hand off to output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Fill the result register, or drop the result once taken
      if (state_q == ST_HOLD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            cnt_q   <= CntW'(SCREEN_WIDTH);
            state_q <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Row shift register and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      odd_q   <= in_data_i.row[0];
      first_q <= first_full[FirstW-1:0];
    end
    if (state_q == ST_SHIFT) begin
      // Odd rows run right to left along the chain
      if (odd_q) begin
        sh_q <= {sh_q[SCREEN_WIDTH-2:0], pix};
      end else begin
        sh_q <= {pix, sh_q[SCREEN_WIDTH-1:1]};
      end
    end
    if (state_q == ST_HOLD && out_free) begin
      out_q.led_bits  <= sh_q;
      out_q.first_led <= first_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/stx_walker.sv */
// ----------------------------------------------------------------------------
// stx_walker: scroll offset and strip column walker
// Keeps the scroll offset as a (character, glyph column) pair and walks the
// text strip one column per cycle while stepping, giving the current pixel.
// ----------------------------------------------------------------------------
module stx_walker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  stx_pkg::stx_ctl_t          ctl_i,
  input  logic [stx_pkg::RowW-1:0]   row_i,
  input  logic [stx_pkg::CodesW-1:0] codes_i,
  input  logic [stx_pkg::ChW-1:0]    last_ch_i,
  output logic                       pix_o
);
  import stx_pkg::*;

  logic [ChW-1:0]  off_ch_q, off_ch_d;
  logic [ColW-1:0] off_g_q, off_g_d;
  logic [ChW-1:0]  cur_ch_q, cur_ch_d;
  logic [ColW-1:0] cur_g_q, cur_g_d;
  logic [RowW-1:0] row_q;

  logic [ChW-1:0]  nxt_off_ch, nxt_cur_ch;
  logic [ColW-1:0] nxt_off_g, nxt_cur_g;

  logic [CodeW-1:0]       code;
  logic [GLYPH_WIDTH-1:0] glyph;
  logic [7:0]             glyph_ext;
  logic [2:0]             bit_idx;

  // Step a strip position one column right, wrapping at the strip end
  always_comb begin
    if (off_g_q == ColW'(CELL_WIDTH - 1)) begin
      nxt_off_g  = '0;
      nxt_off_ch = (off_ch_q == last_ch_i) ? '0 : off_ch_q + 1'b1;
    end else begin
      nxt_off_g  = off_g_q + 1'b1;
      nxt_off_ch = off_ch_q;
    end
    if (cur_g_q == ColW'(CELL_WIDTH - 1)) begin
      nxt_cur_g  = '0;
      nxt_cur_ch = (cur_ch_q == last_ch_i) ? '0 : cur_ch_q + 1'b1;
    end else begin
      nxt_cur_g  = cur_g_q + 1'b1;
      nxt_cur_ch = cur_ch_q;
    end
  end

  // Update offset and walk position
  always_comb begin
    off_ch_d = off_ch_q;
    off_g_d  = off_g_q;
    cur_ch_d = cur_ch_q;
    cur_g_d  = cur_g_q;
    if (ctl_i.clear) begin
      off_ch_d = '0;
      off_g_d  = '0;
    end else if (ctl_i.load) begin
      cur_ch_d = off_ch_q;
      cur_g_d  = off_g_q;
      if (ctl_i.advance) begin
        off_ch_d = nxt_off_ch;
        off_g_d  = nxt_off_g;
      end
    end else if (ctl_i.step) begin
      cur_ch_d = nxt_cur_ch;
      cur_g_d  = nxt_cur_g;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_ch_q <= '0;
      off_g_q  <= '0;
    end else begin
      off_ch_q <= off_ch_d;
      off_g_q  <= off_g_d;
    end
  end

  // Walk position and row are payload
  always_ff @(posedge clk_i) begin
    cur_ch_q <= cur_ch_d;
    cur_g_q  <= cur_g_d;
    if (ctl_i.load) begin
      row_q <= row_i;
    end
  end

  // Pick the pixel of the current strip column
  always_comb begin
    code      = codes_i[CodeW*cur_ch_q +: CodeW];
    glyph     = glyph_row(code, row_q);
    glyph_ext = 8'(glyph);
    bit_idx   = 3'(GLYPH_WIDTH - 1) - 3'(cur_g_q);
    pix_o     = (int'(row_q) < SCREEN_ROWS) && (int'(cur_g_q) < GLYPH_WIDTH)
                && glyph_ext[bit_idx];
  end

endmodule

/* design/stx_check.sv */
// ----------------------------------------------------------------------------
// stx_check: port-level checks for the scrolling text marquee
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module stx_check (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input stx_pkg::out_t              out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  // Stall further requests once one is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while previous one still rendering");

  // No result can appear right after a request is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after request");

  // First LED index is always a row start
  a_first_led_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.first_led == 8'd0 || out_data_o.first_led == 8'd30 ||
                     out_data_o.first_led == 8'd60 || out_data_o.first_led == 8'd90 ||
                     out_data_o.first_led == 8'd120 || out_data_o.first_led == 8'd150 ||
                     out_data_o.first_led == 8'd180 || out_data_o.first_led == 8'd210))
    else $error("first LED index is not a row start");

endmodule

bind scrolling_text_serpentine_matrix stx_check u_stx_check (.*);

/* sim/stx_row_checker.sv */
// ----------------------------------------------------------------------------
// stx_row_checker: row predictor and result comparator for the marquee
// Tracks the text registers and the scroll offset from the configuration
// port and the accepted requests. For each request it renders the expected
// LED row in chain order. Each accepted result is compared field by field
// with the oldest waiting row.
// ----------------------------------------------------------------------------
module stx_row_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  stx_pkg::in_t               in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  stx_pkg::out_t              out_data_i,
  input  logic                       cfg_we_i,
  input  stx_pkg::reg_idx_e          cfg_idx_i,
  input  logic [stx_pkg::CodesW-1:0] cfg_data_i,
  output int unsigned                pending_o,
  output int unsigned                errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // 5x7 letters A, B, C, D, I; MSB of each row is the leftmost column
  localparam logic [0:4][0:6][4:0] LETTER_FONT = {
    5'h04, 5'h0A, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11,
    5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E,
    5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E,
    5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C,
    5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E
  };

  logic [31:0]   text_codes_q;
  logic [3:0]    text_len_q;
  int unsigned   scroll_q;
  stx_pkg::out_t pending_rows[$];

  // Strip width in columns; zero length counts as one letter, overlong as full
  function automatic int unsigned strip_cols(input logic [3:0] len);
    if (len == 4'd0) return stx_pkg::CELL_WIDTH;
    if (len > stx_pkg::MAX_CHARS) return stx_pkg::MAX_CHARS * stx_pkg::CELL_WIDTH;
    return len * stx_pkg::CELL_WIDTH;
  endfunction

  // Look up one glyph row; codes without a letter are blank
  function automatic logic [4:0] letter_row(input logic [3:0] code, input logic [2:0] r);
    if (r >= stx_pkg::GLYPH_ROWS) return 5'h00;
    case (code)
      stx_pkg::CODE_A: return LETTER_FONT[0][r];
      stx_pkg::CODE_B: return LETTER_FONT[1][r];
      stx_pkg::CODE_C: return LETTER_FONT[2][r];
      stx_pkg::CODE_D: return LETTER_FONT[3][r];
      stx_pkg::CODE_I: return LETTER_FONT[4][r];
      default:         return 5'h00;
    endcase
  endfunction

  // Render one matrix row in chain order; odd rows run right to left
  function automatic logic [29:0] render_row(input logic [31:0] codes,
                                             input int unsigned width,
                                             input int unsigned offs,
                                             input logic [2:0]  r);
    logic [29:0] bits;
    int unsigned scr_col;
    int unsigned col;
    int unsigned ch;
    int unsigned g;
    logic [3:0]  code;
    logic [4:0]  glyph;
    bits = '0;
    if (r < stx_pkg::SCREEN_ROWS) begin
      for (int p = 0; p < stx_pkg::SCREEN_WIDTH; p++) begin
        scr_col = r[0] ? stx_pkg::SCREEN_WIDTH - 1 - p : p;
        col     = (scr_col + offs) % width;
        ch      = col / stx_pkg::CELL_WIDTH;
        g       = col % stx_pkg::CELL_WIDTH;
        code    = (ch < 8) ? codes[4*ch +: 4] : stx_pkg::CODE_A;
        if (g < stx_pkg::GLYPH_WIDTH) begin
          glyph   = letter_row(code, r);
          bits[p] = glyph[stx_pkg::GLYPH_WIDTH - 1 - g];
        end
      end
    end
    return bits;
  endfunction

  // Track configuration, predict rows, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    stx_pkg::out_t want;
    int unsigned   width;
    logic          bad;
    if (!rst_ni) begin
      text_codes_q = stx_pkg::TEXT_CODES_RST;
      text_len_q   = stx_pkg::TEXT_LENGTH_RST;
      scroll_q     = 0;
      pending_rows.delete();
      pending_o   <= 0;
      errors_o    <= 0;
    end else begin
      bad = 1'b0;

      // Compare a delivered row with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (pending_rows.size() == 0) begin
          $display("%0t: unexpected row, expected none, got led_bits %h first_led %0d",
                   $time, out_data_i.led_bits, out_data_i.first_led);
          bad = 1'b1;
        end else begin
          want = pending_rows.pop_front();
          if (out_data_i.led_bits !== want.led_bits) begin
            $display("%0t: led_bits mismatch, expected %h, got %h",
                     $time, want.led_bits, out_data_i.led_bits);
            bad = 1'b1;
          end
          if (out_data_i.first_led !== want.first_led) begin
            $display("%0t: first_led mismatch, expected %0d, got %0d",
                     $time, want.first_led, out_data_i.first_led);
            bad = 1'b1;
          end
        end
      end

      // Any register write drops the scroll offset
      if (cfg_we_i) begin
        case (cfg_idx_i)
          stx_pkg::REG_TEXT_CODES:  text_codes_q = cfg_data_i;
          stx_pkg::REG_TEXT_LENGTH: text_len_q   = cfg_data_i[3:0];
          default: ;
        endcase
        scroll_q = 0;
      end

      // Predict the row for an accepted request, then advance the offset
      if (in_valid_i && !in_stall_i) begin
        width = strip_cols(text_len_q);
        if (scroll_q >= width) scroll_q = 0;
        want.led_bits  = render_row(text_codes_q, width, scroll_q, in_data_i.row);
        want.first_led = 8'(in_data_i.row * stx_pkg::SCREEN_WIDTH);
        pending_rows.push_back(want);
        if (in_data_i.advance) scroll_q = (scroll_q + 1 >= width) ? 0 : scroll_q + 1;
      end

      pending_o <= pending_rows.size();
      if (bad) errors_o <= errors_o + 1;
    end
  end

endmodule

/* sim/scrolling_text_serpentine_matrix_tb.sv */
// ----------------------------------------------------------------------------
// scrolling_text_serpentine_matrix_tb: testbench top for the marquee
// Drives row requests and text register writes with random gaps and output
// stalls, including one long output hold-off, and reports the verdict from
// the row checker.
// ----------------------------------------------------------------------------
module scrolling_text_serpentine_matrix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PHASES  = 10;
  localparam int ROWS_PER_PHASE = 95;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 40;

  logic                       clk_i      = 1'b0;
  logic                       rst_ni     = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  stx_pkg::in_t               in_data_i  = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  stx_pkg::out_t              out_data_o;
  logic                       cfg_we_i   = 1'b0;
  stx_pkg::reg_idx_e          cfg_idx_i  = stx_pkg::REG_TEXT_CODES;
  logic [stx_pkg::CodesW-1:0] cfg_data_i = '0;

  int unsigned rows_waiting;
  int unsigned row_errors;
  int unsigned rows_sent;

  scrolling_text_serpentine_matrix i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  stx_row_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (rows_waiting),
    .errors_o    (row_errors)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, a few long
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 70);
  endfunction

  // Random text: letters with glyphs half the time, else extremes or raw bits
  function automatic logic [31:0] pick_codes();
    logic [31:0] v;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    v    = $urandom;
    if (mode < 5) begin
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(0, 4))
          0:       v[4*i +: 4] = stx_pkg::CODE_A;
          1:       v[4*i +: 4] = stx_pkg::CODE_B;
          2:       v[4*i +: 4] = stx_pkg::CODE_C;
          3:       v[4*i +: 4] = stx_pkg::CODE_D;
          default: v[4*i +: 4] = stx_pkg::CODE_I;
        endcase
      end
    end else if (mode == 5) begin
      v = '0;
    end else if (mode == 6) begin
      v = '1;
    end
    return v;
  endfunction

  // Offer one row request, optionally after an idle gap, and wait for accept
  task automatic send_row(input logic [2:0] r, input logic adv, input bit with_gaps);
    int unsigned gap;
    gap = with_gaps ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{row: r, advance: adv};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    rows_sent++;
  endtask

  // Drop valid and wait until every predicted row has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rows_waiting != 0) @(posedge clk_i);
  endtask

  // Write the text registers while the block is idle
  task automatic program_text(input bit wr_codes, input bit wr_len,
                              input logic [31:0] codes, input logic [31:0] len_word);
    if (wr_codes) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= stx_pkg::REG_TEXT_CODES;
      cfg_data_i <= codes;
      @(posedge clk_i);
    end
    if (wr_len) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= stx_pkg::REG_TEXT_LENGTH;
      cfg_data_i <= len_word;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Result side: random stall bursts, one long hold-off once traffic is flowing
  initial begin
    int unsigned run_len;
    int unsigned hold_len;
    bit          long_hold_done;
    long_hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      run_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                             : $urandom_range(1, 30);
      hold_len = idle_len();
      out_stall_i <= 1'b0;
      repeat (run_len) @(posedge clk_i);
      if (!long_hold_done && rows_sent >= 40) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else if (hold_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
      end
    end
  end

  // Stimulus
  initial begin
    bit          eager;
    int unsigned which;
    logic [31:0] len_word;
    logic [3:0]  len;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default text: every row, the row beyond the screen, both parities
    for (int r = 0; r < 8; r++) send_row(3'(r), 1'b0, 1'b1);
    send_row(3'd0, 1'b1, 1'b1);
    send_row(3'd1, 1'b1, 1'b1);
    send_row(3'd6, 1'b1, 1'b1);
    send_row(3'd7, 1'b1, 1'b1);
    drain();

    // Zero length acts as one letter; offset wraps after six columns
    program_text(1'b1, 1'b1, 32'h8888_3210, 32'd0);
    for (int r = 0; r < 7; r++) send_row(3'(r), 1'b1, 1'b0);
    drain();

    // Overlong length with junk above the field, all letters blank
    program_text(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hABCD_123F);
    send_row(3'd0, 1'b1, 1'b1);
    send_row(3'd5, 1'b0, 1'b1);
    drain();

    // Length just past the limit, all letters A
    program_text(1'b1, 1'b1, 32'h0000_0000, 32'd9);
    send_row(3'd3, 1'b1, 1'b1);
    send_row(3'd4, 1'b0, 1'b1);

    // Random phases: new codes, length or both each time, mostly advancing rows
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      which    = $urandom_range(0, 3);
      len      = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 8))
                                            : 4'($urandom_range(0, 15));
      len_word = ($urandom_range(0, 2) == 0) ? $urandom : 32'd0;
      len_word[3:0] = len;
      program_text(which != 1, which != 0, pick_codes(), len_word);
      eager = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < ROWS_PER_PHASE; k++) begin
        send_row(3'($urandom_range(0, 7)), $urandom_range(0, 9) < 7, !eager);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (row_errors == 0) begin
      $display("scrolling_text_serpentine_matrix_tb: done, clean");
    end else begin
      $display("scrolling_text_serpentine_matrix_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("scrolling_text_serpentine_matrix_tb: done, errors");
    $finish;
  end

endmodule

/* sim.f */
design/stx_pkg.sv
design/stx_walker.sv
design/scrolling_text_serpentine_matrix.sv
design/stx_check.sv
sim/stx_row_checker.sv
sim/scrolling_text_serpentine_matrix_tb.sv
